// ----- rtl/mdsr_pkg.sv -----
// Shared constants, types and command codes for the motor duty soft-start ramp.
package mdsr_pkg;

  localparam int DUTY_BITS = 10;
  localparam int STEP_BITS = 10;
  localparam int PCT_BITS  = 7;
  localparam int NUM_DUTY  = 4;

  typedef logic [DUTY_BITS-1:0] duty_t;
  typedef logic [STEP_BITS-1:0] step_t;
  typedef logic [PCT_BITS-1:0]  pct_t;
  typedef logic [1:0]           op_t;
  typedef logic [1:0]           cfg_idx_t;

  // full scale 2^DUTY_BITS - 1
  localparam duty_t FULL_SCALE = '1;
  localparam int    PCT_DIV    = 100;

  localparam op_t CMD_SET    = 2'd0;
  localparam op_t CMD_TICK   = 2'd1;
  localparam op_t CMD_TOGGLE = 2'd2;

  localparam cfg_idx_t REG_RAMP_STEP = 2'd0;
  localparam cfg_idx_t REG_STOP_STEP = 2'd1;
  localparam cfg_idx_t REG_TURN_PCT  = 2'd2;

  localparam step_t RAMP_STEP_RST = 10'd150;
  localparam step_t STOP_STEP_RST = 10'd500;
  localparam pct_t  TURN_PCT_RST  = 7'd50;

  typedef struct packed {
    op_t                    op;
    duty_t [NUM_DUTY-1:0]   tgt;  // 0 right fwd, 1 right rev, 2 left fwd, 3 left rev
  } item_t;

endpackage

// ----- rtl/mdsr_front.sv -----
// Front end: accepts commands, drops the unused code and queues the rest.
module mdsr_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  mdsr_pkg::op_t   command,
  input  mdsr_pkg::duty_t target_right_fwd,
  input  mdsr_pkg::duty_t target_right_rev,
  input  mdsr_pkg::duty_t target_left_fwd,
  input  mdsr_pkg::duty_t target_left_rev,
  output logic            q_valid,
  output mdsr_pkg::item_t q_item,
  input  logic            q_pop
);
  import mdsr_pkg::*;

  item_t      fifo [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       accept;
  logic       keep;
  logic       do_pop;
  item_t      in_item;

  assign full    = (count == 2'd2);
  assign accept  = push && !full;
  // the unused code is taken and discarded here
  assign keep    = accept && ((command == CMD_SET) || (command == CMD_TICK) ||
                              (command == CMD_TOGGLE));
  assign do_pop  = q_pop && q_valid;
  assign q_valid = (count != 2'd0);
  assign q_item  = fifo[rd_ptr];

  // input width equals the duty width, so targets are already within full scale
  always_comb begin
    in_item.op     = command;
    in_item.tgt[0] = target_right_fwd;
    in_item.tgt[1] = target_right_rev;
    in_item.tgt[2] = target_left_fwd;
    in_item.tgt[3] = target_left_rev;
  end

  always_ff @(posedge clk) begin
    if (keep) begin
      fifo[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (keep) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({keep, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/mdsr_core.sv -----
// Back end: ramp engine stepping one duty at a time through a shared multiply chain.
module mdsr_core (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   q_valid,
  input  mdsr_pkg::item_t                        q_item,
  output logic                                   q_pop,
  input  logic                                   cfg_we,
  input  mdsr_pkg::cfg_idx_t                     cfg_index,
  input  mdsr_pkg::step_t                        cfg_data,
  output logic                                   res_valid,
  input  logic                                   res_pop,
  output mdsr_pkg::duty_t [mdsr_pkg::NUM_DUTY-1:0] res_duty,
  output logic                                   res_stop
);
  import mdsr_pkg::*;

  localparam int YW         = DUTY_BITS + PCT_BITS;
  localparam int RW         = YW - 6;
  localparam int RECIP_PCT  = (1 << YW) / PCT_DIV;
  localparam int XW         = DUTY_BITS + STEP_BITS;
  localparam int MW         = ((DUTY_BITS > STEP_BITS) ? DUTY_BITS : STEP_BITS) + 1;

  localparam logic [1:0] RF = 2'd0;
  localparam logic [1:0] RR = 2'd1;
  localparam logic [1:0] LF = 2'd2;
  localparam logic [1:0] LR = 2'd3;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PREP  = 4'd1;
  localparam logic [3:0] S_SCALE = 4'd2;
  localparam logic [3:0] S_RECIP = 4'd3;
  localparam logic [3:0] S_EFF   = 4'd4;
  localparam logic [3:0] S_MULT  = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_MOVE  = 4'd7;
  localparam logic [3:0] S_EMIT  = 4'd8;

  logic [3:0]          state;
  step_t               ramp_step;
  step_t               stop_step;
  pct_t                turn_pct;
  duty_t               cur [NUM_DUTY];
  duty_t               tgt [NUM_DUTY];
  logic                stop_mode;
  logic                turn;
  logic [NUM_DUTY-1:0] hold;
  step_t               base;
  logic [1:0]          lane;
  logic [YW-1:0]       y;
  logic [RW-1:0]       yq0;
  duty_t               eff_r;
  duty_t               ref_r;
  logic [XW-1:0]       x;
  step_t               xq0;

  duty_t               tc [NUM_DUTY];
  logic                turn_next;
  duty_t               e_lane;
  logic [YW-1:0]       y_next;
  logic [YW+RW-1:0]    y_prod;
  logic [YW-1:0]       y_rem;
  logic [RW-1:0]       y_quot;
  duty_t               scaled;
  duty_t               eff_next;
  duty_t               ref_next;
  logic [XW-1:0]       x_next;
  logic [XW:0]         x_sum;
  logic [XW:0]         x_rem;
  step_t               step_q;
  duty_t               cur_next;

  function automatic duty_t move_toward(duty_t c, duty_t t, step_t s);
    logic [MW-1:0] cw;
    logic [MW-1:0] tw;
    logic [MW-1:0] sw;
    logic [MW-1:0] up;
    logic [MW-1:0] dn;
    duty_t         r;
    cw = MW'(c);
    tw = MW'(t);
    sw = MW'(s);
    up = cw + sw;
    dn = cw - sw;
    if (c < t) begin
      r = (up > tw) ? t : up[DUTY_BITS-1:0];
    end else if (c > t) begin
      if (cw <= sw) begin
        r = '0;
      end else begin
        r = (dn < tw) ? t : dn[DUTY_BITS-1:0];
      end
    end else begin
      r = c;
    end
    return r;
  endfunction

  assign q_pop = (state == S_IDLE) && q_valid;

  // clear a side whose forward and reverse targets are both set
  always_comb begin
    for (int i = 0; i < NUM_DUTY; i++) begin
      tc[i] = tgt[i];
    end
    if ((tgt[RF] != '0) && (tgt[RR] != '0)) begin
      tc[RF] = '0;
      tc[RR] = '0;
    end
    if ((tgt[LF] != '0) && (tgt[LR] != '0)) begin
      tc[LF] = '0;
      tc[LR] = '0;
    end
    turn_next = ((tc[RR] != '0) && (tc[LF] != '0) && (tc[RF] == '0) && (tc[LR] == '0)) ||
                ((tc[RF] != '0) && (tc[LR] != '0) && (tc[RR] == '0) && (tc[LF] == '0));
  end

  always_comb begin
    e_lane = stop_mode ? '0 : tgt[lane];
    y_next = YW'(e_lane) * YW'(turn_pct);
    // floor(y / 100): reciprocal estimate, then one correction step
    y_prod = (YW+RW)'(y) * (YW+RW)'(RECIP_PCT);
    y_rem  = y - YW'(yq0) * YW'(PCT_DIV);
    y_quot = yq0 + ((y_rem >= YW'(PCT_DIV)) ? RW'(1) : RW'(0));
    scaled = (y_quot > RW'(FULL_SCALE)) ? FULL_SCALE : y_quot[DUTY_BITS-1:0];
    if (hold[lane]) begin
      eff_next = '0;
    end else if (turn) begin
      eff_next = scaled;
    end else begin
      eff_next = e_lane;
    end
    ref_next = (eff_r > cur[lane]) ? eff_r : cur[lane];
    x_next   = XW'(ref_next) * XW'(base);
    // floor(x / full scale): x + x/2^N, shifted, then one correction step
    x_sum    = (XW+1)'(x) + (XW+1)'(x >> DUTY_BITS);
    x_rem    = (XW+1)'(x) - (XW+1)'({xq0, {DUTY_BITS{1'b0}}}) + (XW+1)'(xq0);
    step_q   = xq0 + ((x_rem >= (XW+1)'(FULL_SCALE)) ? STEP_BITS'(1) : STEP_BITS'(0));
    if ((ref_r != '0) && (step_q == '0)) begin
      step_q = STEP_BITS'(1);
    end
    cur_next = move_toward(cur[lane], eff_r, step_q);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_step <= RAMP_STEP_RST;
      stop_step <= STOP_STEP_RST;
      turn_pct  <= TURN_PCT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RAMP_STEP: ramp_step <= cfg_data;
        REG_STOP_STEP: stop_step <= cfg_data;
        REG_TURN_PCT:  turn_pct  <= cfg_data[PCT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_PREP: begin
        turn    <= turn_next;
        hold[RF] <= (cur[RR] != '0);
        hold[RR] <= (cur[RF] != '0);
        hold[LF] <= (cur[LR] != '0);
        hold[LR] <= (cur[LF] != '0);
        base    <= stop_mode ? stop_step : ramp_step;
      end
      S_SCALE: y     <= y_next;
      S_RECIP: yq0   <= y_prod[YW +: RW];
      S_EFF:   eff_r <= eff_next;
      S_MULT: begin
        ref_r <= ref_next;
        x     <= x_next;
      end
      S_DIV:   xq0   <= x_sum[DUTY_BITS +: STEP_BITS];
      default: ;
    endcase
    if ((state == S_EMIT) && !res_valid) begin
      for (int i = 0; i < NUM_DUTY; i++) begin
        res_duty[i] <= cur[i];
      end
      res_stop <= stop_mode;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      stop_mode <= 1'b0;
      lane      <= 2'd0;
      res_valid <= 1'b0;
      for (int i = 0; i < NUM_DUTY; i++) begin
        cur[i] <= '0;
        tgt[i] <= '0;
      end
    end else begin
      if (res_pop && res_valid) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            unique case (q_item.op)
              CMD_SET: begin
                for (int i = 0; i < NUM_DUTY; i++) begin
                  tgt[i] <= q_item.tgt[i];
                end
              end
              CMD_TOGGLE: stop_mode <= ~stop_mode;
              CMD_TICK:   state     <= S_PREP;
              default: ;
            endcase
          end
        end
        S_PREP: begin
          for (int i = 0; i < NUM_DUTY; i++) begin
            tgt[i] <= tc[i];
          end
          lane  <= 2'd0;
          state <= S_SCALE;
        end
        S_SCALE: state <= S_RECIP;
        S_RECIP: state <= S_EFF;
        S_EFF:   state <= S_MULT;
        S_MULT:  state <= S_DIV;
        S_DIV:   state <= S_MOVE;
        S_MOVE: begin
          cur[lane] <= cur_next;
          lane      <= lane + 2'd1;
          state     <= (lane == LR) ? S_EMIT : S_SCALE;
        end
        S_EMIT: begin
          if (!res_valid) begin
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/motor_duty_soft_start_ramp.sv -----
// Top level of the motor duty soft-start ramp: command queue, ramp engine, result register.
// A tick's duties appear (empty low) after prep, the lane steps and emit; emit waits for a
// free result register. Set and toggle complete in idle; the next command waits for idle.
// The ramp engine walks the four duties in turn, six steps each, through one multiply chain.
// The two-entry command queue and the result register let each side stall independently.
// Synchronous reset clears duties, targets and stop mode and loads the register defaults.
module motor_duty_soft_start_ramp (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  mdsr_pkg::op_t         command,
  input  mdsr_pkg::duty_t       target_right_fwd,
  input  mdsr_pkg::duty_t       target_right_rev,
  input  mdsr_pkg::duty_t       target_left_fwd,
  input  mdsr_pkg::duty_t       target_left_rev,
  output logic                  empty,
  input  logic                  pop,
  output mdsr_pkg::duty_t       duty_right_fwd,
  output mdsr_pkg::duty_t       duty_right_rev,
  output mdsr_pkg::duty_t       duty_left_fwd,
  output mdsr_pkg::duty_t       duty_left_rev,
  output logic                  stop_active,
  input  logic                  cfg_we,
  input  mdsr_pkg::cfg_idx_t    cfg_index,
  input  mdsr_pkg::step_t       cfg_data
);
  import mdsr_pkg::*;

  logic                   q_valid;
  item_t                  q_item;
  logic                   q_pop;
  logic                   res_valid;
  duty_t [NUM_DUTY-1:0]   res_duty;

  mdsr_front u_front (
    .clk              (clk),
    .rst              (rst),
    .push             (push),
    .full             (full),
    .command          (command),
    .target_right_fwd (target_right_fwd),
    .target_right_rev (target_right_rev),
    .target_left_fwd  (target_left_fwd),
    .target_left_rev  (target_left_rev),
    .q_valid          (q_valid),
    .q_item           (q_item),
    .q_pop            (q_pop)
  );

  mdsr_core u_core (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res_valid (res_valid),
    .res_pop   (pop),
    .res_duty  (res_duty),
    .res_stop  (stop_active)
  );

  assign empty          = !res_valid;
  assign duty_right_fwd = res_duty[0];
  assign duty_right_rev = res_duty[1];
  assign duty_left_fwd  = res_duty[2];
  assign duty_left_rev  = res_duty[3];

endmodule

// ----- rtl/mdsr_checker.sv -----
// Port-level checks for the motor duty soft-start ramp, bound to the top level.
module mdsr_checker (
  input logic               clk,
  input logic               rst,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input mdsr_pkg::duty_t    duty_right_fwd,
  input mdsr_pkg::duty_t    duty_right_rev,
  input mdsr_pkg::duty_t    duty_left_fwd,
  input mdsr_pkg::duty_t    duty_left_rev,
  input logic               stop_active
);
  import mdsr_pkg::*;

  // nothing waits on the result side straight after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result waiting after reset");

  // the command queue is drained by reset
  a_reset_not_full: assert property (@(posedge clk) rst |=> !full)
    else $error("input blocked after reset");

  // a waiting transaction holds until taken
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(duty_right_fwd) && $stable(duty_right_rev) &&
                       $stable(duty_left_fwd) && $stable(duty_left_rev) &&
                       $stable(stop_active))
    else $error("result changed while not taken");

  // a side never drives forward and reverse together
  a_right_excl: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (duty_right_fwd == '0) || (duty_right_rev == '0))
    else $error("right side driven both ways");

  a_left_excl: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (duty_left_fwd == '0) || (duty_left_rev == '0))
    else $error("left side driven both ways");

endmodule

bind motor_duty_soft_start_ramp mdsr_checker u_mdsr_checker (
  .clk            (clk),
  .rst            (rst),
  .full           (full),
  .empty          (empty),
  .pop            (pop),
  .duty_right_fwd (duty_right_fwd),
  .duty_right_rev (duty_right_rev),
  .duty_left_fwd  (duty_left_fwd),
  .duty_left_rev  (duty_left_rev),
  .stop_active    (stop_active)
);

// ----- verif/motor_duty_soft_start_ramp_tb.sv -----
// Self-checking testbench for the motor duty soft-start ramp: directed and random commands.
`timescale 1ns / 1ps

module motor_duty_soft_start_ramp_tb;
  import mdsr_pkg::*;

  localparam op_t      CMD_UNUSED   = 2'd3;
  localparam cfg_idx_t REG_NONE     = 2'd3;
  localparam int       RF           = 0;
  localparam int       RR           = 1;
  localparam int       LF           = 2;
  localparam int       LR           = 3;
  localparam int       SETTLE_TICKS = 40;
  localparam int       MAX_REPORTS  = 10;

  typedef duty_t [NUM_DUTY-1:0] duty_quad_t;

  typedef struct packed {
    duty_quad_t duty;
    logic       stop;
  } duty_result_t;

  class ramp_scoreboard;
    int unsigned  ramp_step;
    int unsigned  stop_step;
    int unsigned  turn_pct;
    int unsigned  cur_duty[NUM_DUTY];
    int unsigned  tgt_duty[NUM_DUTY];
    bit           stop_mode;
    duty_result_t expected_duties[$];
    int unsigned  mismatches;

    function new();
      ramp_step  = RAMP_STEP_RST;
      stop_step  = STOP_STEP_RST;
      turn_pct   = TURN_PCT_RST;
      stop_mode  = 1'b0;
      mismatches = 0;
      foreach (cur_duty[i]) begin
        cur_duty[i] = 0;
        tgt_duty[i] = 0;
      end
    endfunction

    function void write_reg(cfg_idx_t idx, step_t data);
      case (idx)
        REG_RAMP_STEP: ramp_step = data;
        REG_STOP_STEP: stop_step = data;
        REG_TURN_PCT:  turn_pct  = data[PCT_BITS-1:0];
        default: ;
      endcase
    endfunction

    function void apply_ramp_tick();
      int unsigned eff[NUM_DUTY];
      int unsigned base;
      int unsigned ref_duty;
      int unsigned step;
      int unsigned fs;
      bit          pivot;
      fs = FULL_SCALE;
      if (tgt_duty[RF] > 0 && tgt_duty[RR] > 0) begin
        tgt_duty[RF] = 0;
        tgt_duty[RR] = 0;
      end
      if (tgt_duty[LF] > 0 && tgt_duty[LR] > 0) begin
        tgt_duty[LF] = 0;
        tgt_duty[LR] = 0;
      end
      foreach (eff[i]) eff[i] = stop_mode ? 0 : tgt_duty[i];
      base = stop_mode ? stop_step : ramp_step;
      // pivot decided on stored targets, even in stop mode
      pivot = (tgt_duty[RR] > 0 && tgt_duty[LF] > 0 && tgt_duty[RF] == 0 && tgt_duty[LR] == 0) ||
              (tgt_duty[RF] > 0 && tgt_duty[LR] > 0 && tgt_duty[RR] == 0 && tgt_duty[LF] == 0);
      if (pivot) begin
        foreach (eff[i]) begin
          eff[i] = eff[i] * turn_pct / PCT_DIV;
          if (eff[i] > fs) eff[i] = fs;
        end
      end
      // no reversal until the opposite side has spun down
      if (cur_duty[RR] > 0) eff[RF] = 0;
      if (cur_duty[RF] > 0) eff[RR] = 0;
      if (cur_duty[LR] > 0) eff[LF] = 0;
      if (cur_duty[LF] > 0) eff[LR] = 0;
      foreach (cur_duty[i]) begin
        ref_duty = (eff[i] > cur_duty[i]) ? eff[i] : cur_duty[i];
        step = ref_duty * base / fs;
        if (ref_duty > 0 && step == 0) step = 1;
        if (cur_duty[i] < eff[i])
          cur_duty[i] = (cur_duty[i] + step > eff[i]) ? eff[i] : cur_duty[i] + step;
        else if (cur_duty[i] > eff[i]) begin
          if (cur_duty[i] <= step)
            cur_duty[i] = 0;
          else
            cur_duty[i] = (cur_duty[i] - step < eff[i]) ? eff[i] : cur_duty[i] - step;
        end
      end
    endfunction

    function void note_input(op_t cmd, duty_quad_t tg);
      duty_result_t res;
      case (cmd)
        CMD_SET: foreach (tgt_duty[i]) tgt_duty[i] = tg[i];
        CMD_TOGGLE: stop_mode = !stop_mode;
        CMD_TICK: begin
          apply_ramp_tick();
          foreach (cur_duty[i]) res.duty[i] = duty_t'(cur_duty[i]);
          res.stop = stop_mode;
          expected_duties.push_back(res);
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(duty_result_t got);
      duty_result_t want;
      int           i;
      if (expected_duties.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result with no tick pending: duties %0d %0d %0d %0d stop %0b",
                   $time, got.duty[RF], got.duty[RR], got.duty[LF], got.duty[LR], got.stop);
        return;
      end
      want = expected_duties.pop_front();
      for (i = 0; i < NUM_DUTY; i++)
        compare_field($sformatf("duty[%0d]", i), want.duty[i], got.duty[i]);
      compare_field("stop_active", want.stop, got.stop);
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst;
  logic       push;
  logic       full;
  op_t        command;
  duty_t      target_right_fwd;
  duty_t      target_right_rev;
  duty_t      target_left_fwd;
  duty_t      target_left_rev;
  logic       empty;
  logic       pop;
  duty_t      duty_right_fwd;
  duty_t      duty_right_rev;
  duty_t      duty_left_fwd;
  duty_t      duty_left_rev;
  logic       stop_active;
  logic       cfg_we;
  cfg_idx_t   cfg_index;
  step_t      cfg_data;

  ramp_scoreboard sb;
  bit             quiet_tail;

  motor_duty_soft_start_ramp DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // transaction monitors on both sides
  always @(posedge clk) begin
    if (!rst && push && !full)
      sb.note_input(command, {target_left_rev, target_left_fwd, target_right_rev,
                              target_right_fwd});
    if (!rst && pop && !empty)
      sb.check_result({{duty_left_rev, duty_left_fwd, duty_right_rev, duty_right_fwd},
                       stop_active});
  end

  // result side back-pressure
  initial begin
    pop <= 1'b0;
    @(negedge rst);
    forever begin
      if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic duty_quad_t quad(duty_t rf, duty_t rr, duty_t lf, duty_t lr);
    return {lr, lf, rr, rf};
  endfunction

  function automatic duty_quad_t noise_quad();
    return duty_quad_t'({$urandom, $urandom});
  endfunction

  function automatic duty_t rand_duty();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return FULL_SCALE;
      2: return duty_t'($urandom_range(1, 8));
      default: return duty_t'($urandom);
    endcase
  endfunction

  // mostly plausible drive patterns; some conflicting ones
  function automatic duty_quad_t pick_targets();
    duty_quad_t t;
    int         i;
    t = '0;
    case ($urandom_range(0, 5))
      0: begin t[RF] = rand_duty(); t[LF] = rand_duty(); end
      1: begin t[RR] = rand_duty(); t[LR] = rand_duty(); end
      2: begin t[RR] = rand_duty(); t[LF] = rand_duty(); end
      3: begin t[RF] = rand_duty(); t[LR] = rand_duty(); end
      4: for (i = 0; i < NUM_DUTY; i++) t[i] = rand_duty();
      default: ;
    endcase
    return t;
  endfunction

  task automatic send_item(op_t cmd, duty_quad_t tg);
    push             <= 1'b1;
    command          <= cmd;
    target_right_fwd <= tg[RF];
    target_right_rev <= tg[RR];
    target_left_fwd  <= tg[LF];
    target_left_rev  <= tg[LR];
    do @(posedge clk); while (full);
  endtask

  task automatic gap(int unsigned n);
    push <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic maybe_gap();
    if (!quiet_tail && $urandom_range(0, 6) == 0) gap($urandom_range(1, 4));
  endtask

  task automatic wait_for_results();
    push <= 1'b0;
    do @(posedge clk); while (sb.expected_duties.size() != 0);
  endtask

  // set and toggle leave no result behind, so let the engine finish them
  task automatic wait_idle();
    wait_for_results();
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic configure(step_t ramp, step_t stop, step_t pct);
    cfg_idx_t idx[4];
    step_t    val[4];
    int       i;
    idx = '{REG_RAMP_STEP, REG_STOP_STEP, REG_TURN_PCT, REG_NONE};
    val = '{ramp, stop, pct, step_t'($urandom)};
    for (i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
      sb.write_reg(idx[i], val[i]);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic directed_items();
    send_item(CMD_TICK, '0);
    send_item(CMD_UNUSED, '1);
    send_item(CMD_SET, quad(FULL_SCALE, '0, '0, '0));
    repeat (3) send_item(CMD_TICK, '0);
    // reverse requested while forward still spinning
    send_item(CMD_SET, quad('0, FULL_SCALE, '0, '0));
    repeat (2) send_item(CMD_TICK, '1);
    send_item(CMD_SET, quad(FULL_SCALE, FULL_SCALE, 10'd1, '0));
    send_item(CMD_TICK, '0);
    send_item(CMD_SET, quad('0, FULL_SCALE, FULL_SCALE, '0));
    repeat (2) send_item(CMD_TICK, '0);
    send_item(CMD_SET, quad(FULL_SCALE, '0, '0, FULL_SCALE));
    send_item(CMD_TICK, '0);
    send_item(CMD_TOGGLE, '0);
    repeat (2) send_item(CMD_TICK, '0);
    send_item(CMD_TOGGLE, '1);
    send_item(CMD_SET, quad(10'h2AA, '0, 10'h155, '0));
    send_item(CMD_TICK, '0);
    send_item(CMD_SET, quad(10'h155, '0, 10'h2AA, '0));
    send_item(CMD_TICK, noise_quad());
  endtask

  task automatic random_phase(int unsigned n_items);
    int unsigned sent;
    sent = 0;
    while (sent < n_items) begin
      send_item(CMD_SET, pick_targets());
      sent++;
      maybe_gap();
      repeat ($urandom_range(1, 14)) begin
        case ($urandom_range(0, 19))
          0: begin send_item(CMD_TOGGLE, noise_quad()); sent++; end
          1: send_item(CMD_UNUSED, noise_quad());
          default: begin send_item(CMD_TICK, noise_quad()); sent++; end
        endcase
        maybe_gap();
      end
      if (!quiet_tail && $urandom_range(0, 39) == 0) wait_for_results();
    end
  endtask

  initial begin
    sb               = new();
    quiet_tail       = 1'b0;
    rst              <= 1'b1;
    push             <= 1'b0;
    command          <= CMD_SET;
    target_right_fwd <= '0;
    target_right_rev <= '0;
    target_left_fwd  <= '0;
    target_left_rev  <= '0;
    cfg_we           <= 1'b0;
    cfg_index        <= REG_RAMP_STEP;
    cfg_data         <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed_items();
    random_phase(300);
    wait_idle();
    configure(10'd1023, 10'd1023, 10'd127);
    random_phase(250);
    wait_idle();
    // zero steps fall back to the minimum step of one
    configure(10'd0, 10'd0, 10'd0);
    random_phase(250);
    wait_idle();
    configure(10'd1, 10'd1, 10'd100);
    random_phase(250);
    wait_idle();
    configure(step_t'($urandom), step_t'($urandom), step_t'($urandom_range(0, 127)));
    random_phase(250);
    wait_idle();
    configure(RAMP_STEP_RST, STOP_STEP_RST, step_t'(TURN_PCT_RST));
    quiet_tail = 1'b1;
    random_phase(300);
    wait_idle();

    if (sb.mismatches == 0 && sb.expected_duties.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
